>>> rtl/core/rfae_pkg.sv
`default_nettype none

package rfae_pkg;

    localparam int DATA_W        = 16;
    localparam int IDX_W         = 3;
    localparam int OP_W          = 4;
    localparam int IMM_W         = 8;
    localparam int BYTE_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int REG_COUNT_DEF = 8;

    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB = 4'd1;
    localparam logic [OP_W-1:0] OP_AND = 4'd2;
    localparam logic [OP_W-1:0] OP_NOR = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV = 4'd5;
    localparam logic [OP_W-1:0] OP_MOD = 4'd6;
    localparam logic [OP_W-1:0] OP_EXP = 4'd7;
    localparam logic [OP_W-1:0] OP_LIZ = 4'd8;
    localparam logic [OP_W-1:0] OP_LIS = 4'd9;
    localparam logic [OP_W-1:0] OP_LUI = 4'd10;

    typedef struct packed {
        logic start;
        logic ack;
    } alu_ctrl_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IMM_W-1:0]  imm;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] old;
    } alu_req_t;

endpackage

`default_nettype wire

>>> rtl/core/register_file_alu_execute.sv
// Opcodes liz, lis, lui, unused opcodes, a zero divisor and a zero exponent go straight to
// the result; add, sub, and, nor and mul work through four 4-bit digits; div and mod
// produce one quotient bit a cycle; exp runs one square-and-multiply step per exponent
// bit, each step running two 16x4 digit lanes over the four digits.
// One item in flight: the next beat is taken the cycle after the result is loaded.
// Asynchronous active-low reset empties the pipeline and reads all REG_COUNT registers (eight by default) as zero.
`default_nettype none

module register_file_alu_execute import rfae_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[3:0], dest_index[6:4], src_a_index[9:7], src_b_index[12:10], immediate[20:13]
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // written_index[2:0], written_value[18:3]
    output logic      [23:0] m_axis_tdata
);

    localparam int AW      = $clog2(REG_COUNT);
    localparam int OP_LO   = 0;
    localparam int DEST_LO = OP_LO + OP_W;
    localparam int SRCA_LO = DEST_LO + IDX_W;
    localparam int SRCB_LO = SRCA_LO + IDX_W;
    localparam int IMM_LO  = SRCB_LO + IDX_W;
    localparam int OUT_W   = IDX_W + DATA_W;

    typedef enum logic [3:0] {
        T_IDLE      = 4'b0001,
        T_READ_SRC  = 4'b0010,
        T_READ_DEST = 4'b0100,
        T_EXEC      = 4'b1000
    } top_state_t;

    top_state_t        state_reg, state_next;
    logic [AW-1:0]     dst_idx_reg;
    logic [OP_W-1:0]   op_reg;
    logic [IMM_W-1:0]  imm_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic              m_valid_reg;
    logic [IDX_W-1:0]  m_index_reg;
    logic [DATA_W-1:0] m_value_reg;

    logic              in_fire;
    logic              wb_fire;
    logic [AW-1:0]     in_src_a;
    logic [AW-1:0]     in_src_b;
    logic [AW-1:0]     raddr0;
    logic [DATA_W-1:0] rdata0;
    logic [DATA_W-1:0] rdata1;
    alu_ctrl_t         alu_ctrl;
    alu_req_t          alu_req;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;

    assign in_src_a = s_axis_tdata[SRCA_LO +: AW];
    assign in_src_b = s_axis_tdata[SRCB_LO +: AW];

    assign s_axis_tready = (state_reg == T_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign wb_fire       = (state_reg == T_EXEC) && alu_done && (!m_valid_reg || m_axis_tready);

    // port 0 reads the first source, then the old destination value
    assign raddr0 = (state_reg == T_IDLE) ? in_src_a : dst_idx_reg;

    rfae_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (wb_fire),
        .waddr  (dst_idx_reg),
        .wdata  (alu_result),
        .raddr0 (raddr0),
        .raddr1 (in_src_b),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    assign alu_ctrl.start = (state_reg == T_READ_DEST);
    assign alu_ctrl.ack   = wb_fire;
    assign alu_req.op     = op_reg;
    assign alu_req.imm    = imm_reg;
    assign alu_req.a      = a_reg;
    assign alu_req.b      = b_reg;
    assign alu_req.old    = rdata0;

    rfae_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .req    (alu_req),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = T_READ_SRC;
                end
            end
            T_READ_SRC:  state_next = T_READ_DEST;
            T_READ_DEST: state_next = T_EXEC;
            T_EXEC:
            begin
                if (wb_fire)
                begin
                    state_next = T_IDLE;
                end
            end
            default:     state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wb_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= s_axis_tdata[OP_LO +: OP_W];
            dst_idx_reg <= s_axis_tdata[DEST_LO +: AW];
            imm_reg     <= s_axis_tdata[IMM_LO +: IMM_W];
        end
        if (state_reg == T_READ_SRC)
        begin
            a_reg <= rdata0;
            b_reg <= rdata1;
        end
        if (wb_fire)
        begin
            m_index_reg <= IDX_W'(dst_idx_reg);
            m_value_reg <= alu_result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{($bits(m_axis_tdata) - OUT_W){1'b0}}, m_value_reg, m_index_reg};

    a_idle_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !alu_done)
        else $error("input taken while a result is pending in the alu");

    a_wb_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        wb_fire |=> m_axis_tvalid && s_axis_tready)
        else $error("writeback did not present a beat and free the input");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_EXEC) && alu_done && m_axis_tvalid && !m_axis_tready |=> alu_done)
        else $error("alu result dropped while output stalled");

endmodule

`default_nettype wire

>>> rtl/core/rfae_ram.sv
`default_nettype none

module rfae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

>>> rtl/core/rfae_regfile.sv
`default_nettype none

module rfae_regfile import rfae_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         we,
    input  wire logic [$clog2(REG_COUNT)-1:0] waddr,
    input  wire logic [DATA_W-1:0]            wdata,
    input  wire logic [$clog2(REG_COUNT)-1:0] raddr0,
    input  wire logic [$clog2(REG_COUNT)-1:0] raddr1,
    output logic      [DATA_W-1:0]            rdata0,
    output logic      [DATA_W-1:0]            rdata1
);

    logic [REG_COUNT-1:0] valid_reg;
    logic                 hit0_reg;
    logic                 hit1_reg;
    logic [DATA_W-1:0]    ram_rdata0;
    logic [DATA_W-1:0]    ram_rdata1;

    rfae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    // an entry never written reads as zero, matching the cleared file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit0_reg  <= 1'b0;
            hit1_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            hit0_reg <= valid_reg[raddr0];
            hit1_reg <= valid_reg[raddr1];
        end
    end

    assign rdata0 = hit0_reg ? ram_rdata0 : '0;
    assign rdata1 = hit1_reg ? ram_rdata1 : '0;

endmodule

`default_nettype wire

>>> rtl/core/rfae_alu.sv
`default_nettype none

module rfae_alu import rfae_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire alu_ctrl_t         ctrl,
    input  wire alu_req_t          req,
    output logic                   done,
    output logic [DATA_W-1:0]      result
);

    localparam int CNT_W  = $clog2(DATA_W);
    localparam int DIGITS = DATA_W / DIGIT_W;
    localparam logic [CNT_W-1:0]  LAST_DIGIT = CNT_W'(DIGITS - 1);
    localparam logic [CNT_W-1:0]  LAST_BIT   = CNT_W'(DATA_W - 1);
    localparam logic [DATA_W-1:0] ONE        = DATA_W'(1);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_LANE = 5'b00010,
        A_DIV  = 5'b00100,
        A_EXP  = 5'b01000,
        A_DONE = 5'b10000
    } alu_state_t;

    alu_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] y_reg, y_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] ss_reg, ss_next;
    logic [DATA_W-1:0] ps_reg, ps_next;
    logic [DATA_W-1:0] exp_reg, exp_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              carry_reg, carry_next;

    logic [DIGIT_W-1:0] dig_a;
    logic [DIGIT_W-1:0] dig_b;
    logic [DIGIT_W:0]   sum_d;
    logic [DIGIT_W-1:0] lane_d;
    logic [DATA_W-1:0]  mul_part;
    logic [DATA_W-1:0]  sum_mul;
    logic [DATA_W-1:0]  sq_part;
    logic [DATA_W-1:0]  ps_sum;
    logic [DATA_W:0]    trial;
    logic [DATA_W:0]    diff;
    logic               div_ge;
    logic [DATA_W-1:0]  rem_new;
    logic [DATA_W-1:0]  quo_new;
    logic [DATA_W-1:0]  r_new;
    logic [DATA_W-1:0]  e_new;

    assign dig_a = x_reg[DIGIT_W-1:0];
    assign dig_b = y_reg[DIGIT_W-1:0];
    assign sum_d = {1'b0, dig_a} + {1'b0, dig_b} + {{DIGIT_W{1'b0}}, carry_reg};

    always_comb
    begin
        case (op_reg) inside
            OP_ADD, OP_SUB: lane_d = sum_d[DIGIT_W-1:0];
            OP_AND:         lane_d = dig_a & dig_b;
            OP_NOR:         lane_d = ~(dig_a | dig_b);
            default:        lane_d = '0;
        endcase
    end

    // one multiplier digit per cycle; the products wrap at the word width
    assign mul_part = x_reg * DATA_W'(dig_b);
    assign sum_mul  = acc_reg + mul_part;
    assign sq_part  = ss_reg * DATA_W'(dig_b);
    assign ps_sum   = ps_reg + sq_part;

    // restoring divide, one quotient bit per cycle
    assign trial   = {rem_reg, x_reg[DATA_W-1]};
    assign div_ge  = trial >= {1'b0, y_reg};
    assign diff    = trial - {1'b0, y_reg};
    assign rem_new = div_ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    assign quo_new = {x_reg[DATA_W-2:0], div_ge};

    assign r_new = exp_reg[0] ? sum_mul : r_reg;
    assign e_new = exp_reg >> 1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rem_next   = rem_reg;
        r_next     = r_reg;
        ss_next    = ss_reg;
        ps_next    = ps_reg;
        exp_next   = exp_reg;
        res_next   = res_reg;
        carry_next = carry_reg;

        unique case (state_reg)
            A_IDLE:
            begin
                if (ctrl.start)
                begin
                    op_next    = req.op;
                    cnt_next   = '0;
                    acc_next   = '0;
                    x_next     = req.a;
                    y_next     = req.b;
                    carry_next = 1'b0;
                    state_next = A_DONE;
                    unique case (req.op) inside
                        OP_ADD, OP_AND, OP_NOR, OP_MUL:
                        begin
                            state_next = A_LANE;
                        end
                        OP_SUB:
                        begin
                            y_next     = ~req.b;
                            carry_next = 1'b1;
                            state_next = A_LANE;
                        end
                        OP_DIV, OP_MOD:
                        begin
                            rem_next = '0;
                            if (req.b == '0)
                            begin
                                res_next = '0;
                            end
                            else
                            begin
                                state_next = A_DIV;
                            end
                        end
                        OP_EXP:
                        begin
                            r_next   = ONE;
                            x_next   = ONE;
                            ss_next  = req.a;
                            y_next   = req.a;
                            ps_next  = '0;
                            exp_next = req.b;
                            if (req.b == '0)
                            begin
                                res_next = ONE;
                            end
                            else
                            begin
                                state_next = A_EXP;
                            end
                        end
                        OP_LIZ:
                        begin
                            res_next = {{(DATA_W-IMM_W){1'b0}}, req.imm};
                        end
                        OP_LIS:
                        begin
                            res_next = {req.imm, {(DATA_W-IMM_W){1'b0}}};
                        end
                        OP_LUI:
                        begin
                            res_next = {req.imm, req.old[BYTE_W-1:0]};
                        end
                        default:
                        begin
                            res_next = req.old;
                        end
                    endcase
                end
            end

            A_LANE:
            begin
                cnt_next = cnt_reg + 1'b1;
                y_next   = y_reg >> DIGIT_W;
                if (op_reg == OP_MUL)
                begin
                    acc_next = sum_mul;
                    x_next   = x_reg << DIGIT_W;
                end
                else
                begin
                    acc_next   = {lane_d, acc_reg[DATA_W-1:DIGIT_W]};
                    x_next     = x_reg >> DIGIT_W;
                    carry_next = sum_d[DIGIT_W];
                end
                if (cnt_reg == LAST_DIGIT)
                begin
                    res_next   = (op_reg == OP_MUL) ? sum_mul
                                                    : {lane_d, acc_reg[DATA_W-1:DIGIT_W]};
                    state_next = A_DONE;
                end
            end

            A_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                rem_next = rem_new;
                x_next   = quo_new;
                if (cnt_reg == LAST_BIT)
                begin
                    res_next   = (op_reg == OP_DIV) ? quo_new : rem_new;
                    state_next = A_DONE;
                end
            end

            A_EXP:
            begin
                cnt_next = cnt_reg + 1'b1;
                acc_next = sum_mul;
                ps_next  = ps_sum;
                x_next   = x_reg << DIGIT_W;
                ss_next  = ss_reg << DIGIT_W;
                y_next   = y_reg >> DIGIT_W;
                if (cnt_reg == LAST_DIGIT)
                begin
                    // both products complete: take one exponent bit, reload the lanes
                    cnt_next = '0;
                    r_next   = r_new;
                    exp_next = e_new;
                    acc_next = '0;
                    ps_next  = '0;
                    x_next   = r_new;
                    ss_next  = ps_sum;
                    y_next   = ps_sum;
                    if (e_new == '0)
                    begin
                        res_next   = r_new;
                        state_next = A_DONE;
                    end
                end
            end

            A_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = A_IDLE;
                end
            end

            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        rem_reg   <= rem_next;
        r_reg     <= r_next;
        ss_reg    <= ss_next;
        ps_reg    <= ps_next;
        exp_reg   <= exp_next;
        res_reg   <= res_next;
        carry_reg <= carry_next;
    end

    assign done   = (state_reg == A_DONE);
    assign result = res_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == A_IDLE)
        else $error("alu started while busy");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == A_DIV |-> y_reg != '0)
        else $error("zero divisor entered the divide loop");

    a_exp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == A_EXP |-> exp_reg != '0)
        else $error("exponent loop running with no bits left");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
    import rfae_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd11;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_TAIL   = 100;
    localparam int DRAIN_POINT  = 475;
    localparam int SETTLE_WAIT  = 80;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  dest;
        logic [IDX_W-1:0]  src_a;
        logic [IDX_W-1:0]  src_b;
        logic [IMM_W-1:0]  imm;
        bit                pinned;
        logic [DATA_W-1:0] pinned_value;
    } plan_row_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } reg_write_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    logic [DATA_W-1:0] reg_shadow [8];
    reg_write_t        pending_writes [$];
    plan_row_t         plan [$];

    logic        idle_on;
    int unsigned stall_left;
    int unsigned tick_total;
    int unsigned failures;
    int unsigned writes_checked;
    int unsigned spare_ops_sent;
    int unsigned beats_sent;

    register_file_alu_execute u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic logic [DATA_W-1:0] alu_result(
        input logic [OP_W-1:0]   op,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] old,
        input logic [IMM_W-1:0]  imm
    );
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] sq;
        logic [DATA_W-1:0] e;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_AND: return a & b;
            OP_NOR: return ~(a | b);
            OP_MUL: return a * b;
            OP_DIV: return (b != 0) ? a / b : '0;
            OP_MOD: return (b != 0) ? a % b : '0;
            OP_EXP:
            begin
                acc = 16'd1;
                sq  = a;
                e   = b;
                for (int k = 0; k < DATA_W; k++)
                begin
                    if (e[0])
                        acc = acc * sq;
                    sq = sq * sq;
                    e  = e >> 1;
                end
                return acc;
            end
            OP_LIZ: return {8'd0, imm};
            OP_LIS: return {imm, 8'd0};
            OP_LUI: return {imm, old[BYTE_W-1:0]};
            default: return old;
        endcase
    endfunction

    function automatic plan_row_t make_row(
        input logic [OP_W-1:0]   op,
        input logic [IDX_W-1:0]  dest,
        input logic [IDX_W-1:0]  src_a,
        input logic [IDX_W-1:0]  src_b,
        input logic [IMM_W-1:0]  imm,
        input bit                pinned,
        input logic [DATA_W-1:0] pinned_value
    );
        plan_row_t r;
        r.op           = op;
        r.dest         = dest;
        r.src_a        = src_a;
        r.src_b        = src_b;
        r.imm          = imm;
        r.pinned       = pinned;
        r.pinned_value = pinned_value;
        return r;
    endfunction

    // Drive one beat, hold it until taken, then queue the register write it causes.
    task automatic send_beat(input plan_row_t r);
        reg_write_t        w;
        logic [DATA_W-1:0] v;
        s_axis_tdata  <= {3'b000, r.imm, r.src_b, r.src_a, r.dest, r.op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        v = alu_result(r.op, reg_shadow[r.src_a], reg_shadow[r.src_b],
                       reg_shadow[r.dest], r.imm);
        reg_shadow[r.dest] = v;
        w.index = r.dest;
        w.value = r.pinned ? r.pinned_value : v;
        pending_writes.insert(pending_writes.size(), w);
        beats_sent++;
        if (r.op > OP_LUI)
            spare_ops_sent++;
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected write beat: index %0d value 0x%04h",
                           m_axis_tdata[2:0], m_axis_tdata[18:3]);
                    failures++;
                end
                else
                begin
                    if (m_axis_tdata[2:0] !== pending_writes[0].index)
                    begin
                        $error("written_index: expected %0d, got %0d",
                               pending_writes[0].index, m_axis_tdata[2:0]);
                        failures++;
                    end
                    if (m_axis_tdata[18:3] !== pending_writes[0].value)
                    begin
                        $error("written_value: expected 0x%04h, got 0x%04h",
                               pending_writes[0].value, m_axis_tdata[18:3]);
                        failures++;
                    end
                    pending_writes.delete(0);
                    writes_checked++;
                end
            end
            if (stall_left != 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left    <= $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        tick_total++;
        if (tick_total == CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        plan_row_t   r;
        int unsigned sel;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        idle_on        = 1'b1;
        stall_left     = 0;
        tick_total     = 0;
        failures       = 0;
        writes_checked = 0;
        spare_ops_sent = 0;
        beats_sent     = 0;
        foreach (reg_shadow[k])
            reg_shadow[k] = '0;

        // registers read as zero right after reset
        plan.push_back(make_row(OP_ADD, 3'd0, 3'd0, 3'd0, 8'h00, 1, 16'h0000));
        plan.push_back(make_row(OP_LIZ, 3'd1, 3'd0, 3'd0, 8'hFF, 1, 16'h00FF));
        plan.push_back(make_row(OP_LIS, 3'd2, 3'd0, 3'd0, 8'hFF, 1, 16'hFF00));
        plan.push_back(make_row(OP_LUI, 3'd1, 3'd0, 3'd0, 8'hAB, 0, 16'h0000));
        plan.push_back(make_row(OP_LIZ, 3'd3, 3'd7, 3'd7, 8'h00, 1, 16'h0000));
        // zero divisor
        plan.push_back(make_row(OP_DIV, 3'd4, 3'd1, 3'd3, 8'h00, 1, 16'h0000));
        plan.push_back(make_row(OP_MOD, 3'd5, 3'd2, 3'd3, 8'h00, 1, 16'h0000));
        // zero exponent with a zero base
        plan.push_back(make_row(OP_EXP, 3'd6, 3'd0, 3'd3, 8'h00, 1, 16'h0001));
        plan.push_back(make_row(OP_NOR, 3'd7, 3'd0, 3'd0, 8'h00, 1, 16'hFFFF));
        plan.push_back(make_row(OP_ADD, 3'd0, 3'd7, 3'd7, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_SUB, 3'd3, 3'd3, 3'd7, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_AND, 3'd4, 3'd1, 3'd2, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_MUL, 3'd5, 3'd7, 3'd7, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_MUL, 3'd6, 3'd2, 3'd2, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_DIV, 3'd4, 3'd7, 3'd3, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_MOD, 3'd5, 3'd1, 3'd2, 8'h00, 0, 16'h0000));
        // full 16-bit exponent, longest square-and-multiply
        plan.push_back(make_row(OP_EXP, 3'd6, 3'd7, 3'd7, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_EXP, 3'd0, 3'd1, 3'd3, 8'h00, 0, 16'h0000));
        // spare opcodes leave the register unchanged
        plan.push_back(make_row(OP_SPARE_LO, 3'd2, 3'd5, 3'd6, 8'h55, 0, 16'h0000));
        plan.push_back(make_row(OP_SPARE_HI, 3'd7, 3'd7, 3'd7, 8'hFF, 0, 16'h0000));
        // destination doubles as source
        plan.push_back(make_row(OP_ADD, 3'd1, 3'd1, 3'd1, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_LUI, 3'd1, 3'd0, 3'd0, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_DIV, 3'd2, 3'd2, 3'd2, 8'h00, 0, 16'h0000));
        plan.push_back(make_row(OP_NOR, 3'd7, 3'd7, 3'd7, 8'h00, 0, 16'h0000));

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        foreach (plan[k])
        begin
            send_beat(plan[k]);
            sender_gap();
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_on <= (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 80) % 4 != 3);
            sel = $urandom_range(0, 99);
            if (sel < 10)
                r.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            else if (sel < 32)
                r.op = OP_W'($urandom_range(OP_LIZ, OP_LUI));
            else
                r.op = OP_W'($urandom_range(OP_ADD, OP_EXP));
            r.dest         = IDX_W'($urandom_range(0, 7));
            r.src_a        = IDX_W'($urandom_range(0, 7));
            r.src_b        = IDX_W'($urandom_range(0, 7));
            r.imm          = IMM_W'($urandom_range(0, 255));
            r.pinned       = 1'b0;
            r.pinned_value = '0;
            send_beat(r);
            if (i == DRAIN_POINT)
            begin
                // hold off until the pipeline has emptied
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_writes.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                sender_gap();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT)
            @(posedge clk);

        $display("sent %0d beats (%0d with spare opcodes) across all eleven ops,",
                 beats_sent, spare_ops_sent);
        $display("checked %0d register writes with back-pressure on both sides",
                 writes_checked);
        if (failures == 0 && pending_writes.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
